[rtl/kcl_pkg.sv]
// Shared types and constants for the keypad code lock controller.
// Holds the item structs, the mode encoding, key and event codes and the
// configuration register indexes. No dependencies.
package kcl_pkg;

    // Code buffers
    localparam int MAX_DIGITS = 15;
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // Failed-attempt counter and its quotient by three
    localparam int ATT_W  = 8;
    localparam int DIV3_W = 7;

    // Counters
    localparam int LOCKDOWN_W  = 16;
    localparam int COUNTDOWN_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCKDOWN_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_COUNTDOWN = 1'd1;

    localparam logic [CFG_DATA_W-1:0] LOCKDOWN_BASE_RST   = 8'd10;
    localparam logic [CFG_DATA_W-1:0] ALARM_COUNTDOWN_RST = 8'd15;

    typedef logic [DIGIT_W-1:0]                  digit_t;
    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  code_t;
    typedef logic [CNT_W-1:0]                    count_t;

    // Factory code 1,2,3,4 (digit 0 in the low nibble)
    localparam code_t        STORED_CODE_RST   = code_t'(16'h4321);
    localparam logic [CNT_W-1:0] STORED_LEN_RST = CNT_W'(4);

    // Event kinds
    typedef enum logic [2:0] {
        EV_KEY     = 3'd0,
        EV_BACK    = 3'd1,
        EV_MOTION  = 3'd2,
        EV_TICK    = 3'd3,
        EV_MSG_DONE = 3'd4
    } kind_t;

    // Special keys
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_STAR       = 4'd10;
    localparam logic [3:0] KEY_HASH       = 4'd11;

    // Lock modes
    typedef enum logic [3:0] {
        M_LOCKED         = 4'd0,
        M_ENTER          = 4'd1,
        M_UNLOCKED       = 4'd2,
        M_NEW            = 4'd3,
        M_CONFIRM        = 4'd4,
        M_ALERT          = 4'd5,
        M_LOCKDOWN       = 4'd6,
        M_MSG_WRONG      = 4'd7,
        M_MSG_CHANGED    = 4'd8,
        M_MSG_NOMATCH    = 4'd9,
        M_MSG_ALERTWRONG = 4'd10
    } mode_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] key_code;
        logic       motion_level;
    } in_item_t;

    typedef struct packed {
        mode_t                   mode;
        logic                    is_unlocked;
        logic                    alert_active;
        logic [3:0]              entry_length;
        logic [LOCKDOWN_W-1:0]   lockdown_remaining;
        logic [ATT_W-1:0]        failed_attempts;
    } out_item_t;

endpackage

[rtl/keypad_code_lock_controller_core.sv]
// Top level of the keypad code lock controller.
// Depends on kcl_pkg and kcl_code_cmp.
//
// Takes one event item per clock cycle while the result side keeps up. The item
// sits in an input register, then one pass of next-state logic updates the lock
// state and fills the result register, which offers the result item. That
// pass holds two parallel code compares and one 8x7 multiply for the lockdown
// reload. Both registers move independently, so a new item is taken every cycle
// while the result side keeps up. The stored code resets to 1,2,3,4. Configuration
// writes change only later reloads of the lockdown and alarm counters.
module keypad_code_lock_controller_core import kcl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Event items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // Result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    // Configuration registers
    logic [CFG_DATA_W-1:0] cfg_base_reg;
    logic [CFG_DATA_W-1:0] cfg_alarm_reg;

    // Input and result registers
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;
    out_item_t out_next;
    logic      advance;

    // Lock state
    mode_t                   mode_reg, mode_next;
    code_t                   stored_code_reg;
    count_t                  stored_len_reg, stored_len_next;
    logic                    stored_load;
    code_t                   entry_digits_reg;
    count_t                  entry_cnt_reg, entry_cnt_next;
    code_t                   confirm_digits_reg;
    count_t                  confirm_cnt_reg, confirm_cnt_next;
    logic [ATT_W-1:0]        attempt_reg, attempt_next;
    logic [1:0]              att_mod3_reg, att_mod3_next;
    logic [DIV3_W-1:0]       att_div3_reg, att_div3_next;
    logic [LOCKDOWN_W-1:0]   lockdown_reg, lockdown_next;
    logic [COUNTDOWN_W-1:0]  countdown_reg, countdown_next;
    logic                    tick_en_reg, tick_en_next;

    // Buffer edits
    logic   is_digit, is_hash, is_star, is_special, key_valid;
    logic   entry_edit, confirm_edit;
    logic   entry_push, entry_pop, confirm_push, confirm_pop;
    count_t entry_edit_cnt, confirm_edit_cnt;

    // Compares and lockdown reload
    logic                    stored_match, confirm_match;
    logic [DIV3_W-1:0]       div3_plus;
    logic [14:0]             reload_prod;
    logic [LOCKDOWN_W-1:0]   lockdown_reload;
    logic [ATT_W-1:0]        attempt_fail;
    logic [1:0]              mod3_fail;
    logic [DIV3_W-1:0]       div3_fail;

    // Handshake: the input register drains into the result register
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Key decode
    assign is_digit   = in_item_reg.key_code <= KEY_LAST_DIGIT;
    assign is_star    = in_item_reg.key_code == KEY_STAR;
    assign is_hash    = in_item_reg.key_code == KEY_HASH;
    assign is_special = is_star || is_hash;
    assign key_valid  = in_item_reg.key_code <= KEY_HASH;

    assign entry_push     = is_digit && (entry_cnt_reg < CNT_W'(MAX_DIGITS));
    assign entry_pop      = is_hash && (entry_cnt_reg != '0);
    assign entry_edit_cnt = entry_push ? entry_cnt_reg + CNT_W'(1) :
                            entry_pop  ? entry_cnt_reg - CNT_W'(1) : entry_cnt_reg;

    assign confirm_push     = is_digit && (confirm_cnt_reg < CNT_W'(MAX_DIGITS));
    assign confirm_pop      = is_hash && (confirm_cnt_reg != '0);
    assign confirm_edit_cnt = confirm_push ? confirm_cnt_reg + CNT_W'(1) :
                              confirm_pop  ? confirm_cnt_reg - CNT_W'(1) : confirm_cnt_reg;

    // Code compares
    kcl_code_cmp u_cmp_stored (
        .code_a (stored_code_reg),
        .len_a  (stored_len_reg),
        .code_b (entry_digits_reg),
        .len_b  (entry_cnt_reg),
        .equal  (stored_match)
    );

    kcl_code_cmp u_cmp_confirm (
        .code_a (confirm_digits_reg),
        .len_a  (confirm_cnt_reg),
        .code_b (entry_digits_reg),
        .len_b  (entry_cnt_reg),
        .equal  (confirm_match)
    );

    // Lockdown reload: base * (1 + failures / 3), quotient kept in a register
    assign div3_plus       = att_div3_reg + DIV3_W'(1);
    assign reload_prod     = 15'(cfg_base_reg) * 15'(div3_plus);
    assign lockdown_reload = LOCKDOWN_W'(reload_prod);

    // Failure count after one more failure, saturating
    always_comb begin
        attempt_fail = attempt_reg;
        mod3_fail    = att_mod3_reg;
        div3_fail    = att_div3_reg;
        if (attempt_reg != '1) begin
            attempt_fail = attempt_reg + ATT_W'(1);
            if (att_mod3_reg == 2'd2) begin
                mod3_fail = 2'd0;
                div3_fail = att_div3_reg + DIV3_W'(1);
            end else begin
                mod3_fail = att_mod3_reg + 2'd1;
            end
        end
    end

    // Next state
    always_comb begin
        mode_next        = mode_reg;
        stored_len_next  = stored_len_reg;
        stored_load      = 1'b0;
        entry_cnt_next   = entry_cnt_reg;
        confirm_cnt_next = confirm_cnt_reg;
        attempt_next     = attempt_reg;
        att_mod3_next    = att_mod3_reg;
        att_div3_next    = att_div3_reg;
        lockdown_next    = lockdown_reg;
        countdown_next   = countdown_reg;
        tick_en_next     = tick_en_reg;
        entry_edit       = 1'b0;
        confirm_edit     = 1'b0;

        case (in_item_reg.kind)
            EV_KEY: begin
                if (key_valid) begin
                    case (mode_reg)
                        M_MSG_WRONG: begin
                            if (is_special) begin
                                entry_cnt_next = '0;
                                mode_next      = M_ENTER;
                            end
                        end
                        M_MSG_CHANGED: begin
                            if (is_special) mode_next = M_UNLOCKED;
                        end
                        M_MSG_NOMATCH: begin
                            if (is_special) begin
                                entry_cnt_next   = '0;
                                confirm_cnt_next = '0;
                                mode_next        = M_NEW;
                            end
                        end
                        M_ENTER: begin
                            if (is_star) begin
                                if (stored_match) begin
                                    attempt_next   = '0;
                                    att_mod3_next  = '0;
                                    att_div3_next  = '0;
                                    tick_en_next   = 1'b0;
                                    countdown_next = cfg_alarm_reg;
                                    mode_next      = M_UNLOCKED;
                                end else begin
                                    attempt_next  = attempt_fail;
                                    att_mod3_next = mod3_fail;
                                    att_div3_next = div3_fail;
                                    if (mod3_fail == 2'd0) begin
                                        tick_en_next = 1'b1;
                                        mode_next    = M_LOCKDOWN;
                                    end else begin
                                        mode_next = M_MSG_WRONG;
                                    end
                                end
                            end else begin
                                entry_edit = 1'b1;
                            end
                        end
                        M_UNLOCKED: begin
                            if (is_star) begin
                                entry_cnt_next   = '0;
                                confirm_cnt_next = '0;
                                mode_next        = M_NEW;
                            end
                        end
                        M_NEW: begin
                            if (is_star) mode_next = M_CONFIRM;
                            else entry_edit = 1'b1;
                        end
                        M_CONFIRM: begin
                            if (is_star) begin
                                if (confirm_match) begin
                                    stored_load     = 1'b1;
                                    stored_len_next = confirm_cnt_reg;
                                    mode_next       = M_MSG_CHANGED;
                                end else begin
                                    mode_next = M_MSG_NOMATCH;
                                end
                            end else begin
                                confirm_edit = 1'b1;
                            end
                        end
                        M_ALERT: begin
                            if (is_star) begin
                                mode_next = stored_match ? M_UNLOCKED : M_MSG_ALERTWRONG;
                            end else begin
                                entry_edit = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            EV_BACK: begin
                case (mode_reg)
                    M_MSG_WRONG, M_UNLOCKED: begin
                        entry_cnt_next = '0;
                        mode_next      = M_ENTER;
                    end
                    M_MSG_CHANGED, M_NEW: mode_next = M_UNLOCKED;
                    M_MSG_NOMATCH, M_CONFIRM: begin
                        entry_cnt_next   = '0;
                        confirm_cnt_next = '0;
                        mode_next        = M_NEW;
                    end
                    default: ;
                endcase
            end
            EV_MOTION: begin
                if (mode_reg != M_ALERT) begin
                    if (in_item_reg.motion_level) begin
                        tick_en_next = 1'b1;
                        mode_next    = M_ENTER;
                    end else begin
                        entry_cnt_next   = '0;
                        confirm_cnt_next = '0;
                        tick_en_next     = 1'b0;
                        countdown_next   = cfg_alarm_reg;
                        mode_next        = M_LOCKED;
                    end
                end
            end
            EV_TICK: begin
                if (tick_en_reg) begin
                    if (mode_reg == M_LOCKDOWN) begin
                        if (lockdown_reg <= LOCKDOWN_W'(1)) begin
                            lockdown_next = lockdown_reload;
                            tick_en_next  = 1'b0;
                            mode_next     = M_ENTER;
                        end else begin
                            lockdown_next = lockdown_reg - LOCKDOWN_W'(1);
                        end
                    end else if (mode_reg == M_ENTER) begin
                        if (countdown_reg <= COUNTDOWN_W'(1)) begin
                            countdown_next = cfg_alarm_reg;
                            tick_en_next   = 1'b0;
                            mode_next      = M_ALERT;
                        end else begin
                            countdown_next = countdown_reg - COUNTDOWN_W'(1);
                        end
                    end
                end
            end
            EV_MSG_DONE: begin
                case (mode_reg)
                    M_MSG_WRONG: begin
                        entry_cnt_next = '0;
                        mode_next      = M_ENTER;
                    end
                    M_MSG_CHANGED: mode_next = M_UNLOCKED;
                    M_MSG_NOMATCH: begin
                        entry_cnt_next   = '0;
                        confirm_cnt_next = '0;
                        mode_next        = M_NEW;
                    end
                    M_MSG_ALERTWRONG: begin
                        entry_cnt_next = '0;
                        mode_next      = M_ALERT;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // Apply digit append or erase
        if (entry_edit) entry_cnt_next = entry_edit_cnt;
        if (confirm_edit) confirm_cnt_next = confirm_edit_cnt;
    end

    // Result item from the updated state
    always_comb begin
        out_next.mode               = mode_next;
        out_next.is_unlocked        = mode_next == M_UNLOCKED;
        out_next.alert_active       = (mode_next == M_ALERT) || (mode_next == M_MSG_ALERTWRONG);
        out_next.entry_length       = (mode_next == M_CONFIRM) ? confirm_cnt_next : entry_cnt_next;
        out_next.lockdown_remaining = lockdown_next;
        out_next.failed_attempts    = attempt_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_base_reg  <= LOCKDOWN_BASE_RST;
            cfg_alarm_reg <= ALARM_COUNTDOWN_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_LOCKDOWN_BASE) cfg_base_reg <= cfg_wdata;
            if (cfg_index == CFG_ALARM_COUNTDOWN) cfg_alarm_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_item_reg <= s_data;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) m_data_reg <= out_next;
    end

    // Lock state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= M_LOCKED;
            stored_code_reg <= STORED_CODE_RST;
            stored_len_reg  <= STORED_LEN_RST;
            entry_cnt_reg   <= '0;
            confirm_cnt_reg <= '0;
            attempt_reg     <= '0;
            att_mod3_reg    <= '0;
            att_div3_reg    <= '0;
            lockdown_reg    <= LOCKDOWN_W'(LOCKDOWN_BASE_RST);
            countdown_reg   <= ALARM_COUNTDOWN_RST;
            tick_en_reg     <= 1'b0;
        end else if (advance) begin
            mode_reg        <= mode_next;
            stored_len_reg  <= stored_len_next;
            entry_cnt_reg   <= entry_cnt_next;
            confirm_cnt_reg <= confirm_cnt_next;
            attempt_reg     <= attempt_next;
            att_mod3_reg    <= att_mod3_next;
            att_div3_reg    <= att_div3_next;
            lockdown_reg    <= lockdown_next;
            countdown_reg   <= countdown_next;
            tick_en_reg     <= tick_en_next;
            if (stored_load) stored_code_reg <= confirm_digits_reg;
        end
    end

    // Digit buffers; only positions below the count are ever read
    always_ff @(posedge aclk) begin
        if (advance && entry_edit && entry_push) begin
            entry_digits_reg[entry_cnt_reg] <= in_item_reg.key_code;
        end
        if (advance && confirm_edit && confirm_push) begin
            confirm_digits_reg[confirm_cnt_reg] <= in_item_reg.key_code;
        end
    end

endmodule

[rtl/kcl_code_cmp.sv]
// Parallel compare of two digit codes with their lengths.
// Depends on kcl_pkg for the code and count types.
module kcl_code_cmp import kcl_pkg::*; (
    input  code_t  code_a,
    input  count_t len_a,
    input  code_t  code_b,
    input  count_t len_b,
    output logic   equal
);

    logic [MAX_DIGITS-1:0] digit_ok;

    // Check every position; positions past the length always pass
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_ok[i] = (CNT_W'(i) >= len_a) || (code_a[i] == code_b[i]);
        end
    end

    assign equal = (len_a == len_b) && (len_a <= CNT_W'(MAX_DIGITS)) && (&digit_ok);

endmodule

[rtl/kcl_checker.sv]
// Port-level checks for the keypad code lock controller, bound to the top.
// Depends on kcl_pkg and keypad_code_lock_controller_core.
module kcl_checker import kcl_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Hold a stalled result item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Unlock flag follows the mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.is_unlocked == (m_data.mode == M_UNLOCKED))
        else $error("is_unlocked disagrees with mode");

    // Alert flag follows the mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.alert_active ==
            ((m_data.mode == M_ALERT) || (m_data.mode == M_MSG_ALERTWRONG)))
        else $error("alert_active disagrees with mode");

    // Locked mode always shows an empty entry buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.mode == M_LOCKED) |-> m_data.entry_length == '0)
        else $error("entry buffer not empty while locked");

endmodule

bind keypad_code_lock_controller_core kcl_checker u_kcl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
